// ===== rtl/rau_pkg.sv =====
// Shared types, widths and codes for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int W = 32;
  localparam int DW = 2 * W;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] early;
    logic early_hit;
    logic [W-1:0] a_num;
    logic [W-1:0] a_den;
    logic [W-1:0] b_num;
    logic [W-1:0] b_den;
  } job_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-2:0] den;
    logic less;
    logic equal;
    logic [1:0] status;
  } res_t;
endpackage

// ===== rtl/rau_front.sv =====
// Front end: accepts items, classifies errors and unused codes, feeds a two-entry queue.
// Depends on rau_pkg.
module rau_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0] kind,
  input  logic signed [rau_pkg::W-1:0] a_num,
  input  logic signed [rau_pkg::W-1:0] a_den,
  input  logic signed [rau_pkg::W-1:0] b_num,
  input  logic signed [rau_pkg::W-1:0] b_den,
  output logic q_valid,
  output rau_pkg::job_t q_job,
  input  logic q_take
);
  rau_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  rau_pkg::job_t j;
  logic wr, rd;

  always_comb begin
    j.kind = kind;
    j.a_num = a_num;
    j.a_den = a_den;
    j.b_num = b_num;
    j.b_den = b_den;
    j.early = rau_pkg::ST_OK;
    j.early_hit = 1'b0;
    if (kind > rau_pkg::OP_CMP) begin
      j.early_hit = 1'b1;
    end else if (a_den == '0) begin
      j.early_hit = 1'b1;
      j.early = rau_pkg::ST_ZDEN;
    end else if (kind != rau_pkg::OP_NEG && b_den == '0) begin
      j.early_hit = 1'b1;
      j.early = rau_pkg::ST_ZDEN;
    end else if (kind == rau_pkg::OP_DIV && b_num == '0) begin
      j.early_hit = 1'b1;
      j.early = rau_pkg::ST_DIVZ;
    end
  end

  assign full = cnt == 2'd2;
  assign q_valid = cnt != 2'd0;
  assign wr = push && !full;
  assign rd = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= j;
    end
  end
  assign q_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  a_no_over: assert property (@(posedge clk) disable iff (rst) full |-> !wr)
    else $error("write while full");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
      (cnt == 2'd0 || cnt == 2'd2) |-> wp == rp)
    else $error("pointers disagree with count");
`endif
endmodule

// ===== rtl/rau_back.sv =====
// Back end: sequencer running gcd, serial division and 32x32 products per job.
// Depends on rau_pkg.
module rau_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  rau_pkg::job_t q_job,
  output logic q_take,
  output logic r_valid,
  output rau_pkg::res_t r_data,
  input  logic r_take
);
  localparam int DW = rau_pkg::DW;
  localparam int W = rau_pkg::W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOAD  = 14'b00000000000010,
    S_RED   = 14'b00000000000100,
    S_GCD   = 14'b00000000001000,
    S_DIV   = 14'b00000000010000,
    S_RDONE = 14'b00000000100000,
    S_OP0   = 14'b00000001000000,
    S_OP1   = 14'b00000010000000,
    S_OP2   = 14'b00000100000000,
    S_OP3   = 14'b00001000000000,
    S_OP4   = 14'b00010000000000,
    S_OP5   = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } st_t;

  st_t st;
  rau_pkg::job_t job;
  logic [1:0] phase;
  logic ra_neg, rb_neg, rr_neg;
  logic [W-1:0] am, ad, bm, bd;
  logic red_neg;
  logic [DW-1:0] rm, rd;
  logic [DW-1:0] ga, gb;
  logic [6:0] gk;
  logic gpre;
  logic [DW-1:0] gres;
  logic [DW-1:0] dvn, dvq, dvr, dvd;
  logic [6:0] dbit;
  logic dsel;
  logic [DW-1:0] qm, qd;
  logic red_only_g;
  logic [DW-1:0] p0, p1;
  logic [W-1:0] da, db;
  logic [DW-1:0] lcm_g;
  rau_pkg::res_t res;
  logic [DW-1:0] rem_sh;
  logic [DW:0] diff;
  logic fits;

  function automatic logic [W-1:0] absw(input logic [W-1:0] v);
    absw = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign q_take = st == S_IDLE && q_valid && !r_valid;
  assign rem_sh = {dvr[DW-2:0], (dbit == 7'(DW)) ? dvn[DW-1] : dvn[dbit[5:0]]};
  assign diff = {1'b0, rem_sh} - {1'b0, dvd};
  assign fits = (rr_neg ? (rm <= {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}})
                        : (rm < {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}}))
                && rd < {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      r_valid <= 1'b0;
    end else begin
      if (r_valid && r_take) r_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (q_take) begin
            job <= q_job;
            st <= q_job.early_hit ? S_OUT : S_LOAD;
            res.num <= '0;
            res.den <= {{(W-2){1'b0}}, 1'b1};
            res.less <= 1'b0;
            res.equal <= 1'b0;
            res.status <= q_job.early;
            phase <= 2'd0;
          end
        end
        S_LOAD: begin
          if (phase == 2'd0) begin
            red_neg <= job.a_num[W-1] ^ job.a_den[W-1];
            rm <= {{(DW-W){1'b0}}, absw(job.a_num)};
            rd <= {{(DW-W){1'b0}}, absw(job.a_den)};
          end else begin
            red_neg <= job.b_num[W-1] ^ job.b_den[W-1];
            rm <= {{(DW-W){1'b0}}, absw(job.b_num)};
            rd <= {{(DW-W){1'b0}}, absw(job.b_den)};
          end
          red_only_g <= 1'b0;
          st <= S_RED;
        end
        S_RED: begin
          ga <= rm;
          gb <= rd;
          gk <= '0;
          gpre <= 1'b1;
          st <= S_GCD;
        end
        S_GCD: begin
          if (ga == '0) begin
            gres <= gb;
            st <= S_DIV;
            dsel <= 1'b0;
            dbit <= 7'(DW - 1);
          end else if (gb == '0) begin
            gres <= ga << gk;
            st <= S_DIV;
            dsel <= 1'b0;
            dbit <= 7'(DW - 1);
          end else if (gpre && !ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 7'd1;
          end else if (!ga[0]) begin
            gpre <= 1'b0;
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gpre <= 1'b0;
            gb <= gb >> 1;
          end else begin
            gpre <= 1'b0;
            if (ga > gb) begin
              ga <= gb;
              gb <= ga - gb;
            end else begin
              gb <= gb - ga;
            end
          end
          if (!(ga == '0 || gb == '0)) begin
            dvr <= '0;
            dvq <= '0;
          end
        end
        S_DIV: begin
          if (dbit == 7'(DW - 1)) begin
            dvn <= dsel ? rd : rm;
            dvd <= gres;
            dvr <= '0;
            dvq <= '0;
            dbit <= 7'(DW);
          end else if (dbit == 7'(DW)) begin
            dbit <= 7'(DW - 1) - 7'd1;
            if (diff[DW]) begin
              dvr <= rem_sh;
              dvq <= {dvq[DW-2:0], 1'b0};
            end else begin
              dvr <= diff[DW-1:0];
              dvq <= {dvq[DW-2:0], 1'b1};
            end
          end else begin
            if (diff[DW]) begin
              dvr <= rem_sh;
              dvq <= {dvq[DW-2:0], 1'b0};
            end else begin
              dvr <= diff[DW-1:0];
              dvq <= {dvq[DW-2:0], 1'b1};
            end
            if (dbit == '0) begin
              if (!dsel) begin
                qm <= {dvq[DW-2:0], !diff[DW]};
                dsel <= 1'b1;
                dbit <= 7'(DW - 1);
              end else begin
                qd <= {dvq[DW-2:0], !diff[DW]};
                st <= S_RDONE;
              end
            end else begin
              dbit <= dbit - 7'd1;
            end
          end
        end
        S_RDONE: begin
          if (red_only_g) begin
            da <= qm[W-1:0];
            db <= qd[W-1:0];
            st <= S_OP1;
          end else begin
            rm <= qm;
            rd <= qd;
            rr_neg <= (qm == '0) ? 1'b0 : red_neg;
            if (phase == 2'd0) begin
              ra_neg <= (qm == '0) ? 1'b0 : red_neg;
              am <= qm[W-1:0];
              ad <= qd[W-1:0];
              phase <= 2'd1;
              st <= (job.kind == rau_pkg::OP_NEG) ? S_OP5 : S_LOAD;
            end else if (phase == 2'd1) begin
              rb_neg <= (qm == '0) ? 1'b0 : red_neg;
              bm <= qm[W-1:0];
              bd <= qd[W-1:0];
              phase <= 2'd2;
              st <= S_OP0;
            end else begin
              st <= S_FIN;
            end
          end
        end
        S_OP0: begin
          unique case (job.kind)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              rm <= {{(DW-W){1'b0}}, ad};
              rd <= {{(DW-W){1'b0}}, bd};
              red_only_g <= 1'b1;
              st <= S_RED;
            end
            rau_pkg::OP_MUL: begin
              red_neg <= ra_neg ^ rb_neg;
              rm <= DW'(am) * DW'(bm);
              st <= S_OP2;
            end
            rau_pkg::OP_DIV: begin
              red_neg <= ra_neg ^ rb_neg;
              rm <= DW'(am) * DW'(bd);
              st <= S_OP3;
            end
            default: begin
              p0 <= DW'(am) * DW'(bd);
              st <= S_OP4;
            end
          endcase
        end
        S_OP1: begin
          p0 <= DW'(am) * DW'(db);
          p1 <= DW'(bm) * DW'(da);
          lcm_g <= DW'(da) * DW'(bd);
          st <= S_OP2;
        end
        S_OP2: begin
          if (job.kind == rau_pkg::OP_MUL) begin
            rd <= DW'(ad) * DW'(bd);
          end else begin
            if (ra_neg == (rb_neg ^ (job.kind == rau_pkg::OP_SUB))) begin
              red_neg <= ra_neg;
              rm <= p0 + p1;
            end else if (p0 >= p1) begin
              red_neg <= ra_neg;
              rm <= p0 - p1;
            end else begin
              red_neg <= rb_neg ^ (job.kind == rau_pkg::OP_SUB);
              rm <= p1 - p0;
            end
            rd <= lcm_g;
          end
          red_only_g <= 1'b0;
          st <= S_RED;
        end
        S_OP3: begin
          rd <= DW'(ad) * DW'(bm);
          red_only_g <= 1'b0;
          st <= S_RED;
        end
        S_OP4: begin
          p1 <= DW'(bm) * DW'(ad);
          st <= S_OP5;
        end
        S_OP5: begin
          if (job.kind == rau_pkg::OP_NEG) begin
            rr_neg <= (am == '0) ? 1'b0 : !ra_neg;
            rm <= {{(DW-W){1'b0}}, am};
            rd <= {{(DW-W){1'b0}}, ad};
            st <= S_FIN;
          end else begin
            if (ra_neg != rb_neg) begin
              res.equal <= (p0 == '0) && (p1 == '0);
              res.less <= ra_neg && !((p0 == '0) && (p1 == '0));
            end else if (p0 >= p1) begin
              res.equal <= p0 == p1;
              res.less <= ra_neg && (p0 != p1);
            end else begin
              res.less <= !ra_neg;
            end
            st <= S_OUT;
          end
        end
        S_FIN: begin
          if (fits) begin
            res.num <= rr_neg ? (~rm[W-1:0] + 1'b1) : rm[W-1:0];
            res.den <= rd[W-2:0];
          end else begin
            res.status <= rau_pkg::ST_OVF;
          end
          st <= S_OUT;
        end
        S_OUT: begin
          r_valid <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      if (st == S_RDONE && !red_only_g && phase == 2'd2) phase <= 2'd2;
    end
  end

  assign r_data = res;

`ifndef SYNTHESIS
  a_st: assert property (@(posedge clk) disable iff (rst) $onehot(st))
    else $error("state not one-hot");
  a_take: assert property (@(posedge clk) disable iff (rst) q_take |-> !r_valid)
    else $error("took job while result pending");
  a_out: assert property (@(posedge clk) disable iff (rst) st == S_OUT |=> r_valid)
    else $error("result not raised");
`endif
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: front queue plus back sequencer.
// Depends on rau_pkg, rau_front, rau_back.
//
//   channel  | handshake     | fields
//   input    | push / full   | kind a_num a_den b_num b_den
//   result   | pop / empty   | res_num res_den is_less is_equal status
//
// Each of up to four reductions per item runs a binary gcd (one shift or subtract
// per cycle) then two 64-step serial divisions. Error and unused codes skip the
// arithmetic and go straight to the output state. Reset is synchronous and clears
// the front queue and the pending result. The front queue holds two items while
// the back end works or the result waits unread.
module rational_arithmetic_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0] kind,
  input  logic signed [rau_pkg::W-1:0] a_num,
  input  logic signed [rau_pkg::W-1:0] a_den,
  input  logic signed [rau_pkg::W-1:0] b_num,
  input  logic signed [rau_pkg::W-1:0] b_den,
  output logic empty,
  input  logic pop,
  output logic signed [rau_pkg::W-1:0] res_num,
  output logic [rau_pkg::W-2:0] res_den,
  output logic is_less,
  output logic is_equal,
  output logic [1:0] status
);
  logic q_valid, q_take, r_valid;
  rau_pkg::job_t q_job;
  rau_pkg::res_t r_data;

  rau_front u_front (
    .clk, .rst, .push, .full, .kind, .a_num, .a_den, .b_num, .b_den,
    .q_valid, .q_job, .q_take
  );

  rau_back u_back (
    .clk, .rst, .q_valid, .q_job, .q_take, .r_valid, .r_data, .r_take(pop)
  );

  assign empty = !r_valid;
  assign res_num = r_data.num;
  assign res_den = r_data.den;
  assign is_less = r_data.less;
  assign is_equal = r_data.equal;
  assign status = r_data.status;
endmodule
